>>> src/plti_pkg.sv
`timescale 1ns / 1ps

package plti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = 8;
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NUM_W       = 32;
    localparam int KNOT_W      = 2 * NUM_W;
    localparam int STEPS       = NUM_W;
    localparam int CNT_W       = $clog2(STEPS);
    localparam int SUM_W       = 2 * NUM_W + 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PRIME,
        S_SCAN,
        S_CLAMP,
        S_ARITH,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        AR_IDLE,
        AR_DZ,
        AR_DD,
        AR_DV,
        AR_MAG,
        AR_MUL,
        AR_RND,
        AR_DIV,
        AR_FIN
    } t_ar_state;

    typedef struct packed {
        logic signed [NUM_W-1:0] d0;
        logic signed [NUM_W-1:0] d1;
        logic signed [NUM_W-1:0] v0;
        logic signed [NUM_W-1:0] v1;
        logic signed [NUM_W-1:0] z;
    } t_seg;

endpackage

>>> src/plti_ram.sv
`timescale 1ns / 1ps

module plti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/plti_lerp.sv
`timescale 1ns / 1ps

// Shared 66-bit add/sub: operand prep, shift-add multiply, rounding,
// restoring divide and final offset, one step per cycle.
module plti_lerp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  plti_pkg::t_seg                 i_seg,
    output logic                           o_done,
    output logic [plti_pkg::NUM_W-1:0]     o_result
);

    localparam int N = plti_pkg::NUM_W;
    localparam int S = plti_pkg::SUM_W;

    plti_pkg::t_ar_state r_state, n_state;

    plti_pkg::t_seg            r_seg;
    logic [N-1:0]              r_dz;
    logic [N-1:0]              r_dd;
    logic [N-1:0]              r_mag;
    logic                      r_neg;
    logic [2*N:0]              r_p;
    logic [plti_pkg::CNT_W-1:0] r_cnt;
    logic                      r_done;
    logic [N-1:0]              r_res;

    logic [S-1:0] a_op, b_op, sum;
    logic         sub;
    logic         last_step;
    logic [N:0]   div_r;

    assign last_step = (r_cnt == plti_pkg::CNT_W'(plti_pkg::STEPS - 1));
    assign sum       = a_op + (b_op ^ {S{sub}}) + S'(sub);
    assign div_r     = sum[S-1] ? r_p[2*N-1:N-1] : sum[N:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plti_pkg::AR_IDLE: if (i_start) n_state = plti_pkg::AR_DZ;
            plti_pkg::AR_DZ:   n_state = plti_pkg::AR_DD;
            plti_pkg::AR_DD:   n_state = plti_pkg::AR_DV;
            plti_pkg::AR_DV:   n_state = plti_pkg::AR_MAG;
            plti_pkg::AR_MAG:  n_state = plti_pkg::AR_MUL;
            plti_pkg::AR_MUL:  if (last_step) n_state = plti_pkg::AR_RND;
            plti_pkg::AR_RND:  n_state = plti_pkg::AR_DIV;
            plti_pkg::AR_DIV:  if (last_step) n_state = plti_pkg::AR_FIN;
            plti_pkg::AR_FIN:  n_state = plti_pkg::AR_IDLE;
            default:           n_state = plti_pkg::AR_IDLE;
        endcase
    end

    always_comb begin
        a_op = '0;
        b_op = '0;
        sub  = 1'b0;
        unique case (r_state)
            plti_pkg::AR_DZ: begin
                a_op = S'(r_seg.z);
                b_op = S'(r_seg.d0);
                sub  = 1'b1;
            end
            plti_pkg::AR_DD: begin
                a_op = S'(r_seg.d1);
                b_op = S'(r_seg.d0);
                sub  = 1'b1;
            end
            plti_pkg::AR_DV: begin
                a_op = S'(r_seg.v1);
                b_op = S'(r_seg.v0);
                sub  = 1'b1;
            end
            plti_pkg::AR_MAG: begin
                b_op = {{(S-N-1){r_neg}}, r_neg, r_mag};
                sub  = r_neg;
            end
            plti_pkg::AR_MUL: begin
                a_op = S'(r_p[2*N-1:N]);
                b_op = r_p[0] ? S'(r_mag) : '0;
            end
            plti_pkg::AR_RND: begin
                a_op = S'(r_p);
                b_op = S'(r_dd[N-1:1]);
            end
            plti_pkg::AR_DIV: begin
                a_op = S'(r_p[2*N-1:N-1]);
                b_op = S'(r_dd);
                sub  = 1'b1;
            end
            plti_pkg::AR_FIN: begin
                a_op = S'(r_seg.v0);
                b_op = S'(r_p[N-1:0]);
                sub  = r_neg;
            end
            default: begin
                a_op = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plti_pkg::AR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == plti_pkg::AR_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            plti_pkg::AR_IDLE: if (i_start) r_seg <= i_seg;
            plti_pkg::AR_DZ:   r_dz <= sum[N-1:0];
            plti_pkg::AR_DD:   r_dd <= sum[N-1:0];
            plti_pkg::AR_DV: begin
                r_mag <= sum[N-1:0];
                r_neg <= sum[N];
                r_p   <= {(N+1)'(0), r_dz};
                r_cnt <= '0;
            end
            plti_pkg::AR_MAG:  r_mag <= sum[N-1:0];
            plti_pkg::AR_MUL: begin
                r_p   <= {1'b0, sum[N:0], r_p[N-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            plti_pkg::AR_RND: begin
                r_p   <= sum[2*N:0];
                r_cnt <= '0;
            end
            plti_pkg::AR_DIV: begin
                r_p   <= {div_r, r_p[N-2:0], ~sum[S-1]};
                r_cnt <= r_cnt + 1'b1;
            end
            // result stays between the two knot values, no saturation needed
            plti_pkg::AR_FIN:  r_res <= sum[N-1:0];
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> src/piecewise_linear_table_interp.sv
`timescale 1ns / 1ps

// Piecewise linear interpolation over a 256-entry knot table (signed Q16.16).
// A load word (tuser = 0) writes one knot and gives no result.
// A query word (tuser = 1) scans the segments first..last-1, one segment per
// cycle out of the single table read port, then interpolates in a shared
// add/sub unit: 32 multiply steps, 32 divide steps and a handful of setup
// steps. The input is not ready while a query is in progress. The result sits
// in an output register, so the next word is taken while it waits.
module piecewise_linear_table_interp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, entry_depth, entry_value, region_first, region_last, query_depth
    input  logic [119:0] s_axis_tdata,
    // op
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // interp_value
    output logic [31:0]  m_axis_tdata,
    // clamped
    output logic [0:0]   m_axis_tuser
);

    localparam int N  = plti_pkg::NUM_W;
    localparam int IW = plti_pkg::IDX_W;
    localparam int AW = plti_pkg::AW;

    plti_pkg::t_state r_state, n_state;

    logic [IW-1:0]         in_idx, in_first, in_last;
    logic signed [N-1:0]   in_depth, in_value, in_z;
    logic                  in_acc;

    logic [IW-1:0]         r_first, r_last, r_k;
    logic signed [N-1:0]   r_z, r_d0, r_v0;
    logic                  r_rd_ok;
    logic [N-1:0]          r_res;
    logic                  r_clamp;
    logic                  r_out_valid;
    logic [N-1:0]          r_out_data;
    logic                  r_out_clamp;

    logic [IW-1:0]           raddr;
    logic                    we;
    logic [plti_pkg::KNOT_W-1:0] rdata;
    logic signed [N-1:0]     d1, v1;
    logic                    hit, can_emit, emit, ar_start, ar_done;
    logic [N-1:0]            ar_result;
    plti_pkg::t_seg          seg;

    assign in_idx   = s_axis_tdata[7:0];
    assign in_depth = s_axis_tdata[39:8];
    assign in_value = s_axis_tdata[71:40];
    assign in_first = s_axis_tdata[79:72];
    assign in_last  = s_axis_tdata[87:80];
    assign in_z     = s_axis_tdata[119:88];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign d1       = r_rd_ok ? rdata[N-1:0] : '0;
    assign v1       = r_rd_ok ? rdata[2*N-1:N] : '0;
    assign hit      = (r_z >= r_d0) && (r_z < d1);
    assign can_emit = !r_out_valid || m_axis_tready;

    assign seg = '{d0: r_d0, d1: d1, v0: r_v0, v1: v1, z: r_z};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plti_pkg::S_IDLE: begin
                if (in_acc && s_axis_tuser[0] == plti_pkg::OP_QUERY) n_state = plti_pkg::S_START;
            end
            plti_pkg::S_START: begin
                n_state = (r_last > r_first) ? plti_pkg::S_PRIME : plti_pkg::S_CLAMP;
            end
            plti_pkg::S_PRIME: n_state = plti_pkg::S_SCAN;
            plti_pkg::S_SCAN: begin
                priority if (hit)            n_state = plti_pkg::S_ARITH;
                else if (r_k == r_last)      n_state = plti_pkg::S_EMIT;
                else                         n_state = plti_pkg::S_SCAN;
            end
            plti_pkg::S_CLAMP: n_state = plti_pkg::S_EMIT;
            plti_pkg::S_ARITH: if (ar_done) n_state = plti_pkg::S_EMIT;
            plti_pkg::S_EMIT:  if (can_emit) n_state = plti_pkg::S_IDLE;
            default:           n_state = plti_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        we            = 1'b0;
        raddr         = r_k;
        ar_start      = 1'b0;
        emit          = 1'b0;
        unique case (r_state)
            plti_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                we = in_acc && (s_axis_tuser[0] == plti_pkg::OP_LOAD)
                     && (32'(in_idx) < 32'(plti_pkg::TABLE_DEPTH));
            end
            plti_pkg::S_START: raddr = (r_last > r_first) ? r_first : r_last;
            plti_pkg::S_PRIME: raddr = r_k + 1'b1;
            plti_pkg::S_SCAN: begin
                raddr    = r_k + 1'b1;
                ar_start = hit;
            end
            plti_pkg::S_EMIT:  emit = can_emit;
            default: begin
                raddr = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plti_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= 32'(raddr) < 32'(plti_pkg::TABLE_DEPTH);
        if (emit) begin
            r_out_data  <= r_res;
            r_out_clamp <= r_clamp;
        end
        unique case (r_state)
            plti_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_first <= in_first;
                    r_last  <= in_last;
                    r_z     <= in_z;
                end
            end
            plti_pkg::S_START: r_k <= r_first;
            plti_pkg::S_PRIME: begin
                r_d0 <= d1;
                r_v0 <= v1;
                r_k  <= r_k + 1'b1;
            end
            plti_pkg::S_SCAN: begin
                if (!hit) begin
                    r_d0    <= d1;
                    r_v0    <= v1;
                    r_k     <= r_k + 1'b1;
                    r_res   <= v1;
                    r_clamp <= 1'b1;
                end
            end
            plti_pkg::S_CLAMP: begin
                r_res   <= v1;
                r_clamp <= 1'b1;
            end
            plti_pkg::S_ARITH: begin
                r_res   <= ar_result;
                r_clamp <= 1'b0;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    plti_ram #(
        .WIDTH (plti_pkg::KNOT_W),
        .DEPTH (plti_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(in_idx)),
        .i_wdata ({in_value, in_depth}),
        .i_raddr (AW'(raddr)),
        .o_rdata (rdata)
    );

    plti_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ar_start),
        .i_seg    (seg),
        .o_done   (ar_done),
        .o_result (ar_result)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_clamp;

endmodule

>>> src/plti_check.sv
`timescale 1ns / 1ps

module plti_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [0:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a query occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("input ready straight after a query");

    // a load does not occupy the block
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
        else $error("input not ready after a load");

    // a fresh result comes only out of query work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind piecewise_linear_table_interp plti_check u_plti_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/piecewise_linear_table_interp_check.sv
`timescale 1ns / 1ps

module piecewise_linear_table_interp_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [119:0] i_in_data,
    input  logic [0:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [31:0]  i_out_data,
    input  logic [0:0]   i_out_user,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic signed [31:0] value;
        logic               clamped;
    } t_interp;

    logic signed [31:0] knot_depth [plti_pkg::TABLE_DEPTH];
    logic signed [31:0] knot_value [plti_pkg::TABLE_DEPTH];
    t_interp            expected_interp [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 50) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic queue_expected(input t_interp item);
        expected_interp = {expected_interp, item};
    endtask

    function automatic logic signed [31:0] lerp_knots(
        input logic signed [31:0] v0, input logic signed [31:0] v1,
        input logic signed [31:0] d0, input logic signed [31:0] d1,
        input logic signed [31:0] z);
        logic signed [33:0] dv;
        logic signed [33:0] dd;
        logic signed [33:0] dz;
        logic signed [33:0] mag;
        logic signed [33:0] r;
        logic [65:0]        num;
        logic [65:0]        quo;
        dv  = {{2{v1[31]}}, v1} - {{2{v0[31]}}, v0};
        dd  = {{2{d1[31]}}, d1} - {{2{d0[31]}}, d0};
        dz  = {{2{z[31]}}, z} - {{2{d0[31]}}, d0};
        mag = dv[33] ? -dv : dv;
        num = {32'd0, mag} * {32'd0, dz} + ({32'd0, dd} >> 1);
        quo = num / {32'd0, dd};
        if (dv[33]) begin
            r = {{2{v0[31]}}, v0} - quo[33:0];
        end else begin
            r = {{2{v0[31]}}, v0} + quo[33:0];
        end
        if (r[33:31] != 3'b000 && r[33:31] != 3'b111) begin
            return r[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r[31:0];
    endfunction

    function automatic t_interp interpolate_knots(input int first, input int last,
                                                 input logic signed [31:0] z);
        t_interp res;
        res.value   = knot_value[last];
        res.clamped = 1'b1;
        for (int k = first; k < last; k++) begin
            if (z >= knot_depth[k] && z < knot_depth[k+1]) begin
                res.value   = lerp_knots(knot_value[k], knot_value[k+1],
                                         knot_depth[k], knot_depth[k+1], z);
                res.clamped = 1'b0;
                break;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_interp want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_user[0] == plti_pkg::OP_LOAD) begin
                    knot_depth[i_in_data[7:0]] = i_in_data[39:8];
                    knot_value[i_in_data[7:0]] = i_in_data[71:40];
                end else begin
                    queue_expected(interpolate_knots(
                        int'(i_in_data[79:72]), int'(i_in_data[87:80]),
                        i_in_data[119:88]));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_interp.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word value=%h clamped=%b",
                                              i_out_data, i_out_user[0]));
                end else begin
                    want = expected_interp.pop_front();
                    if (i_out_data !== want.value) begin
                        report_mismatch($sformatf("interp_value %h, expected %h",
                                                  i_out_data, want.value));
                    end
                    if (i_out_user[0] !== want.clamped) begin
                        report_mismatch($sformatf("clamped %b, expected %b",
                                                  i_out_user[0], want.clamped));
                    end
                end
            end
            o_pending = expected_interp.size();
        end
    end

endmodule

>>> verif/piecewise_linear_table_interp_test.sv
`timescale 1ns / 1ps

module piecewise_linear_table_interp_test;

    localparam int ITEM_TARGET = 1250;
    localparam int IDLE_LIMIT  = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit calm;
    int run_base;
    int run_end;
    int pick;
    int n;
    int f;
    int l;
    bit found;

    bit                 written      [plti_pkg::TABLE_DEPTH];
    logic signed [31:0] loaded_depth [plti_pkg::TABLE_DEPTH];

    always #4 i_clk = ~i_clk;

    piecewise_linear_table_interp uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    piecewise_linear_table_interp_check result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic longint rand_range64(input longint lo, input longint hi);
        longint span;
        span = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % 64'(span));
    endfunction

    task automatic send_word(input logic op, input logic [119:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Unused fields carry junk
    task automatic send_load(input int idx, input logic [31:0] depth, input logic [31:0] value);
        written[idx]      = 1'b1;
        loaded_depth[idx] = depth;
        send_word(plti_pkg::OP_LOAD, {$urandom, 16'($urandom), value, depth, 8'(idx)});
    endtask

    task automatic send_query(input int first, input int last, input logic [31:0] z);
        send_word(plti_pkg::OP_QUERY,
                  {z, 8'(last), 8'(first), $urandom, $urandom, 8'($urandom)});
    endtask

    function automatic bit region_ok(input int a, input int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        for (int k = lo; k <= hi; k++) begin
            if (!written[k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_depth(input int first, input int last);
        int     r;
        int     k;
        longint d0;
        longint d1;
        r  = $urandom_range(0, 99);
        k  = (last > first) ? $urandom_range(first, last - 1) : first;
        d0 = longint'(loaded_depth[k]);
        d1 = (last > first) ? longint'(loaded_depth[k+1]) : d0;
        if (r < 55 && d1 > d0) begin
            return 32'(rand_range64(d0, d1 - 1));
        end
        if (r < 70) begin
            return loaded_depth[$urandom_range(first, last)];
        end
        if (r < 78 && loaded_depth[first] != 32'sh8000_0000) begin
            return 32'(rand_range64(-64'sd2147483648, longint'(loaded_depth[first]) - 1));
        end
        if (r < 86) begin
            return 32'(rand_range64(longint'(loaded_depth[last]), 64'sd2147483647));
        end
        return $urandom;
    endfunction

    // Ascending knots with random spacing, an occasional repeated depth
    task automatic load_run(input int base, input int len);
        int     mode;
        longint max_step;
        longint cur;
        logic [31:0] value;
        mode     = $urandom_range(0, 2);
        max_step = (mode == 0) ? 1000 : (mode == 1) ? (64'sd1 << 20) : (64'sh0FFFF_FFFF / len);
        cur      = rand_range64(-64'sd2147483648, 64'sd2147483647 - (len - 1) * max_step);
        for (int i = 0; i < len; i++) begin
            value = $urandom_range(0, 1) ? $urandom : 32'(rand_range64(-(1 << 20), 1 << 20));
            send_load(base + i, 32'(cur), value);
            if ($urandom_range(0, 19) != 0) begin
                cur += rand_range64(1, max_step);
            end
        end
        run_base = base;
        run_end  = base + len - 1;
    endtask

    task automatic query_in(input int lo, input int hi);
        int a;
        int b;
        if ($urandom_range(0, 4) == 0) begin
            a = lo;
            b = hi;
        end else begin
            a = $urandom_range(lo, hi - 1);
            b = $urandom_range(a + 1, hi);
        end
        send_query(a, b, pick_depth(a, b));
    endtask

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("piecewise_linear_table_interp_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int hi_len;
        int lo_len;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            hi_len = calm ? 1 : $urandom_range(1, 8);
            repeat (hi_len - 1) @(negedge i_clk);
            lo_len = idle_len();
            if (lo_len > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (lo_len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_cycles   = 0;
        items_sent    = 0;
        calm          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extreme knots: full-range depths and values
        send_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_load(1, 32'hFFFF_FFFF, 32'h8000_0000);
        send_load(2, 32'h0000_0000, 32'h0000_0000);
        send_load(3, 32'h7FFF_FFFF, 32'h0001_2345);
        send_query(0, 3, 32'h8000_0000);
        send_query(0, 3, 32'hFFFF_FFFE);
        send_query(0, 3, 32'h7FFF_FFFE);
        send_query(0, 3, 32'h7FFF_FFFF);
        send_query(1, 3, 32'h8000_0000);
        send_query(2, 2, 32'h0000_0000);
        send_query(3, 0, 32'h0000_0005);
        // Half-way ties, rounding away from zero both ways
        send_load(4, 32'h0000_0000, 32'h0000_0000);
        send_load(5, 32'h0000_0002, 32'h0000_0001);
        send_query(4, 5, 32'h0000_0001);
        send_load(5, 32'h0000_0002, 32'hFFFF_FFFF);
        send_query(4, 5, 32'h0000_0001);
        // Equal then descending knots never match
        send_load(6, 32'h0005_0000, 32'h0000_0007);
        send_load(7, 32'h0005_0000, 32'h0000_0009);
        send_load(8, 32'h0004_0000, 32'h0000_000B);
        send_query(6, 8, 32'h0005_0000);
        send_load(255, 32'h7FFF_FFFF, 32'h8000_0000);
        send_load(254, 32'h8000_0000, 32'h7FFF_FFFF);
        send_query(254, 255, 32'h0000_0000);
        send_query(0, 8, 32'h7FFF_FFFF);
        run_base = 0;
        run_end  = 3;

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 59) == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                n = ($urandom_range(0, 39) == 0) ? $urandom_range(32, 256)
                                                 : $urandom_range(2, 10);
                load_run($urandom_range(0, plti_pkg::TABLE_DEPTH - n), n);
                repeat ($urandom_range(2, 6)) query_in(run_base, run_end);
            end else if (pick < 80) begin
                query_in(run_base, run_end);
            end else if (pick < 88) begin
                found = 1'b0;
                for (int t = 0; t < 8 && !found; t++) begin
                    f = $urandom_range(0, plti_pkg::TABLE_DEPTH - 2);
                    l = f + $urandom_range(1, 12);
                    if (l > plti_pkg::TABLE_DEPTH - 1) begin
                        l = plti_pkg::TABLE_DEPTH - 1;
                    end
                    found = region_ok(f, l);
                end
                if (found) begin
                    send_query(f, l, pick_depth(f, l));
                end else begin
                    query_in(run_base, run_end);
                end
            end else if (pick < 95) begin
                send_load($urandom_range(0, plti_pkg::TABLE_DEPTH - 1), $urandom, $urandom);
            end else begin
                // empty region: last at or below first
                f = $urandom_range(run_base, run_end);
                l = $urandom_range(run_base, f);
                send_query(f, l, $urandom);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("piecewise_linear_table_interp_test passed");
        end else begin
            $display("piecewise_linear_table_interp_test failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/plti_pkg.sv
src/plti_ram.sv
src/plti_lerp.sv
src/piecewise_linear_table_interp.sv
src/plti_check.sv
verif/piecewise_linear_table_interp_check.sv
verif/piecewise_linear_table_interp_test.sv
